// ===== hdl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, codes and command byte table for the SD SPI sector reader.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned CRC_BYTES    = 2;
  localparam int unsigned CMD_LEN      = 6;

  localparam int unsigned SECTOR_W = 23;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned STEP_W   = 10;

  localparam logic [STEP_W-1:0] BLOCK_END = STEP_W'(SECTOR_BYTES + CRC_BYTES);
  localparam logic [STEP_W-1:0] CMD_LAST  = STEP_W'(CMD_LEN - 1);

  localparam logic [1:0] OP_SEEK = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_RX   = 2'd2;

  localparam logic [1:0] WARN_NONE     = 2'd0;
  localparam logic [1:0] WARN_NO_R1    = 2'd1;
  localparam logic [1:0] WARN_NO_TOKEN = 2'd2;

  localparam logic [7:0] CMD17_BYTE  = 8'h51;
  localparam logic [7:0] START_TOKEN = 8'hFE;
  localparam logic [7:0] R1_READY    = 8'h00;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;

  localparam logic [7:0] POLL_TRIES_RESET = 8'd100;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD,
    PH_R1,
    PH_TOKEN,
    PH_BLOCK
  } phase_e;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [1:0] warning;
  } result_t;

  function automatic logic [7:0] cmd_byte(input logic [STEP_W-1:0] idx,
                                          input logic [SECTOR_W-1:0] sector);
    logic [7:0] b;
    case (idx)
      10'd0:   b = CMD17_BYTE;
      10'd1:   b = sector[22:15];
      10'd2:   b = sector[14:7];
      10'd3:   b = {sector[6:0], 1'b0};
      10'd4:   b = 8'h00;
      default: b = FILL_BYTE;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/sd_spi_partial_sector_reader.sv =====
// ----------------------------------------------------------------------------
// sd_spi_partial_sector_reader
// Byte-level sequencer for single-block SD card reads in SPI mode.
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream is a seek, a read start or a byte
// received from the card. Every request yields exactly one result on the
// master stream: the next byte to shift out (tuser bit 0 marks it valid),
// chip select, a requested data byte (tuser bit 1 marks it valid), and on
// the result that ends a read, tlast with a warning code in tuser.
// A read sends CMD17 with the byte address, polls for the zero R1 and the
// start token up to max_poll_tries bytes each, walks the 512 sector bytes
// and two CRC bytes, then releases chip select and advances the position.
// Pipeline: a request passes through the input register, then the result
// register, before its result is offered on the master stream.
// Throughput: one request per cycle while the receiver keeps tready high;
// the per-byte state update is a single pass of narrow compares and adds.
// Stall: when the receiver holds tready low the result register holds and
// the input register fills; tready on the slave side drops only when both
// are occupied. Reset clears the position, sector and phase and sets
// max_poll_tries to 100; the APB port is always ready.
// ----------------------------------------------------------------------------
module sd_spi_partial_sector_reader (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] byte_address, [39:32] read_count, [47:40] rx_byte
  input  logic [47:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_byte, [8] chip_select, [16:9] data_byte, [23:17] zero
  output logic [23:0] m_axis_tdata,
  // [0] tx_valid, [1] data_valid, [3:2] warning
  output logic [3:0]  m_axis_tuser,
  // done_res
  output logic        m_axis_tlast
);
  import sdspi_pkg::*;

  logic [7:0] max_poll_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, max_poll_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_poll_q <= POLL_TRIES_RESET;
    end else if (cfg_wr) begin
      max_poll_q <= pwdata[7:0];
    end
  end

  // input register
  logic        in_v_q;
  logic [1:0]  op_q;
  logic [31:0] addr_q;
  logic [7:0]  cnt_q;
  logic [7:0]  rx_q;
  logic        out_v_q;
  result_t     out_q;
  logic        out_adv;
  logic        fire;

  assign out_adv       = !out_v_q || m_axis_tready;
  assign fire          = in_v_q && out_adv;
  assign s_axis_tready = !in_v_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q   <= s_axis_tuser;
      addr_q <= s_axis_tdata[31:0];
      cnt_q  <= s_axis_tdata[39:32];
      rx_q   <= s_axis_tdata[47:40];
    end
  end

  // sequencer state
  phase_e              phase_q, phase_d;
  logic [SECTOR_W-1:0] sector_q, sector_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [POS_W-1:0]    start_q, start_d;
  logic [POS_W-1:0]    len_q, len_d;
  logic [7:0]          tries_q, tries_d;
  logic [1:0]          pwarn_q, pwarn_d;
  result_t             res;

  logic [STEP_W-1:0] room;
  logic [STEP_W-1:0] span_end;
  logic [STEP_W-1:0] step_inc;
  logic [STEP_W-1:0] pos_sum;
  logic [7:0]        poll_lim;
  logic [7:0]        tries_inc;
  logic [7:0]        want;
  logic              poll_next;

  assign room      = STEP_W'(SECTOR_BYTES) - {1'b0, pos_q};
  assign span_end  = {1'b0, start_q} + {1'b0, len_q};
  assign step_inc  = step_q + 1'b1;
  assign pos_sum   = {1'b0, pos_q} + {1'b0, len_q};
  assign poll_lim  = (max_poll_q == 8'd0) ? 8'd1 : max_poll_q;
  assign tries_inc = tries_q + 1'b1;
  assign want      = (phase_q == PH_R1) ? R1_READY : START_TOKEN;

  always_comb begin
    phase_d   = phase_q;
    sector_d  = sector_q;
    pos_d     = pos_q;
    step_d    = step_q;
    start_d   = start_q;
    len_d     = len_q;
    tries_d   = tries_q;
    pwarn_d   = pwarn_q;
    res       = '0;
    poll_next = 1'b0;
    if (phase_q == PH_IDLE) begin
      if (op_q == OP_SEEK) begin
        sector_d = addr_q[31:9];
        pos_d    = addr_q[8:0];
      end else if (op_q == OP_READ) begin
        start_d         = pos_q;
        len_d           = ({2'b00, cnt_q} < room) ? {1'b0, cnt_q} : room[POS_W-1:0];
        pwarn_d         = WARN_NONE;
        tries_d         = 8'd0;
        step_d          = '0;
        phase_d         = PH_CMD;
        res.tx_valid    = 1'b1;
        res.tx_byte     = cmd_byte('0, sector_q);
        res.chip_select = 1'b1;
      end
    end else if (op_q != OP_RX) begin
      res.chip_select = 1'b1;
    end else begin
      res.chip_select = 1'b1;
      res.tx_valid    = 1'b1;
      res.tx_byte     = FILL_BYTE;
      case (phase_q)
        PH_CMD: begin
          if (step_q < CMD_LAST) begin
            step_d      = step_inc;
            res.tx_byte = cmd_byte(step_inc, sector_q);
          end else begin
            phase_d = PH_R1;
            tries_d = 8'd0;
          end
        end
        PH_R1, PH_TOKEN: begin
          if (rx_q == want) begin
            poll_next = 1'b1;
          end else begin
            tries_d = tries_inc;
            if (tries_inc >= poll_lim) begin
              poll_next = 1'b1;
              if (pwarn_q == WARN_NONE) begin
                pwarn_d = (phase_q == PH_R1) ? WARN_NO_R1 : WARN_NO_TOKEN;
              end
            end
          end
          if (poll_next) begin
            tries_d = 8'd0;
            step_d  = '0;
            phase_d = (phase_q == PH_R1) ? PH_TOKEN : PH_BLOCK;
          end
        end
        PH_BLOCK: begin
          if (step_q >= {1'b0, start_q} && step_q < span_end) begin
            res.data_valid = 1'b1;
            res.data_byte  = rx_q;
          end
          step_d = step_inc;
          if (step_inc >= BLOCK_END) begin
            res.tx_valid    = 1'b0;
            res.tx_byte     = 8'd0;
            res.chip_select = 1'b0;
            res.done_res    = 1'b1;
            res.warning     = pwarn_q;
            if (pos_sum >= STEP_W'(SECTOR_BYTES)) begin
              pos_d    = '0;
              sector_d = sector_q + 1'b1;
            end else begin
              pos_d = pos_sum[POS_W-1:0];
            end
            step_d  = '0;
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      sector_q <= '0;
      pos_q    <= '0;
      step_q   <= '0;
      start_q  <= '0;
      len_q    <= '0;
      tries_q  <= '0;
      pwarn_q  <= WARN_NONE;
    end else if (fire) begin
      phase_q  <= phase_d;
      sector_q <= sector_d;
      pos_q    <= pos_d;
      step_q   <= step_d;
      start_q  <= start_d;
      len_q    <= len_d;
      tries_q  <= tries_d;
      pwarn_q  <= pwarn_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, out_q.data_byte, out_q.chip_select, out_q.tx_byte};
  assign m_axis_tuser  = {out_q.warning, out_q.data_valid, out_q.tx_valid};
  assign m_axis_tlast  = out_q.done_res;

  // checks
  a_data_needs_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tdata[8])
    else $error("data byte outside chip select");

  a_done_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tdata[8] && !m_axis_tuser[0]))
    else $error("done result still selects the card");

  a_warn_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[3:2] != WARN_NONE)) |-> m_axis_tlast)
    else $error("warning outside done result");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BLOCK) |-> (step_q < BLOCK_END))
    else $error("block step counter overran");

  a_len_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (span_end <= STEP_W'(SECTOR_BYTES)))
    else $error("requested span runs past sector end");

endmodule
